/* design/slad_pkg.sv */
// Shared types, register codes and color constants of the shift light and alarm LED driver.
package slad_pkg;

  localparam int unsigned NumLeds    = 7;
  localparam int unsigned ColorW     = 24;
  localparam int unsigned InDataW    = 88;
  localparam int unsigned OutDataW   = NumLeds * ColorW;
  localparam int unsigned CfgAddrW   = 5;
  localparam int unsigned CfgDataW   = 32;

  localparam logic [31:0] StrobePeriodMs = 32'd60;
  localparam logic [16:0] LadderSpanRpm  = 17'd1600;
  localparam logic [16:0] RedMarginRpm   = 17'd50;
  localparam logic [14:0] BatteryMinMv   = 15'd1000;

  localparam logic [ColorW-1:0] ColOff     = 24'h000000;
  localparam logic [ColorW-1:0] ColGreen   = 24'h00FF00;
  localparam logic [ColorW-1:0] ColAmber   = 24'hFFC800;
  localparam logic [ColorW-1:0] ColOrange  = 24'hFF7800;
  localparam logic [ColorW-1:0] ColRed     = 24'hFF0000;
  localparam logic [ColorW-1:0] ColBlue    = 24'h0096FF;
  localparam logic [ColorW-1:0] ColBattery = 24'hFF6400;
  localparam logic [ColorW-1:0] ColMagenta = 24'hFF00C8;
  localparam logic [ColorW-1:0] ColWhite   = 24'hFFFFFF;

  typedef enum logic [2:0] {
    REG_SHIFT_ENABLE    = 3'd0,
    REG_SHIFT_POINT_RPM = 3'd1,
    REG_ALARM_ENABLE    = 3'd2,
    REG_WATER_ALARM_C   = 3'd3,
    REG_LOW_BATTERY_MV  = 3'd4,
    REG_EXHAUST_ALARM_C = 3'd5,
    REG_REV_LIMIT_RPM   = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic        shift_enable;
    logic [15:0] shift_point_rpm;
    logic        alarm_enable;
    logic [7:0]  water_alarm_c;
    logic [14:0] low_battery_mv;
    logic [10:0] exhaust_alarm_c;
    logic [15:0] rev_limit_rpm;
  } cfg_t;

  typedef struct packed {
    logic [10:0]        egt_c;
    logic [14:0]        battery_mv;
    logic signed [8:0]  coolant_c;
    logic [15:0]        engine_rpm;
    logic [31:0]        now_ms;
  } item_t;

  typedef logic [NumLeds-1:0][ColorW-1:0] led_vec_t;

endpackage

/* design/slad_cfg.sv */
// Configuration register file with its APB-style access port.
module slad_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [slad_pkg::CfgAddrW-1:0]  cfg_paddr,
  input  logic [slad_pkg::CfgDataW-1:0]  cfg_pwdata,
  output logic [slad_pkg::CfgDataW-1:0]  cfg_prdata,
  output logic                           cfg_pready,
  output slad_pkg::cfg_t                 cfg
);
  import slad_pkg::*;

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  logic     wr_en;
  reg_idx_t idx;
  logic     idx_ok;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  // Indexes past the last register are ignored.
  assign idx_ok     = (cfg_paddr[4:2] <= REG_REV_LIMIT_RPM);
  assign idx        = reg_idx_t'(cfg_paddr[4:2]);

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en && idx_ok) begin
      unique case (idx)
        REG_SHIFT_ENABLE:    cfg_nxt.shift_enable    = cfg_pwdata[0];
        REG_SHIFT_POINT_RPM: cfg_nxt.shift_point_rpm = cfg_pwdata[15:0];
        REG_ALARM_ENABLE:    cfg_nxt.alarm_enable    = cfg_pwdata[0];
        REG_WATER_ALARM_C:   cfg_nxt.water_alarm_c   = cfg_pwdata[7:0];
        REG_LOW_BATTERY_MV:  cfg_nxt.low_battery_mv  = cfg_pwdata[14:0];
        REG_EXHAUST_ALARM_C: cfg_nxt.exhaust_alarm_c = cfg_pwdata[10:0];
        REG_REV_LIMIT_RPM:   cfg_nxt.rev_limit_rpm   = cfg_pwdata[15:0];
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    cfg_prdata = '0;
    unique case (idx)
      REG_SHIFT_ENABLE:    cfg_prdata = {31'd0, cfg_r.shift_enable};
      REG_SHIFT_POINT_RPM: cfg_prdata = {16'd0, cfg_r.shift_point_rpm};
      REG_ALARM_ENABLE:    cfg_prdata = {31'd0, cfg_r.alarm_enable};
      REG_WATER_ALARM_C:   cfg_prdata = {24'd0, cfg_r.water_alarm_c};
      REG_LOW_BATTERY_MV:  cfg_prdata = {17'd0, cfg_r.low_battery_mv};
      REG_EXHAUST_ALARM_C: cfg_prdata = {21'd0, cfg_r.exhaust_alarm_c};
      REG_REV_LIMIT_RPM:   cfg_prdata = {16'd0, cfg_r.rev_limit_rpm};
      default:             cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.shift_enable    <= 1'b1;
      cfg_r.shift_point_rpm <= 16'd7000;
      cfg_r.alarm_enable    <= 1'b1;
      cfg_r.water_alarm_c   <= 8'd105;
      cfg_r.low_battery_mv  <= 15'd3400;
      cfg_r.exhaust_alarm_c <= 11'd850;
      cfg_r.rev_limit_rpm   <= 16'd0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* design/slad_strobe.sv */
// Strobe phase and last toggle time, advanced once per word moved to the result stage.
module slad_strobe (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        advance,
  input  logic [31:0] now_ms,
  output logic        phase
);
  logic        phase_r;
  logic        phase_nxt;
  logic [31:0] last_ms_r;
  logic [31:0] last_ms_nxt;
  logic [31:0] elapsed;
  logic        toggle;

  import slad_pkg::*;

  // Elapsed time wraps modulo 2^32 like the timestamp itself.
  assign elapsed     = now_ms - last_ms_r;
  assign toggle      = (elapsed >= StrobePeriodMs);
  assign phase_nxt   = toggle ? ~phase_r : phase_r;
  assign last_ms_nxt = toggle ? now_ms : last_ms_r;
  assign phase       = phase_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= 1'b0;
      last_ms_r <= 32'd0;
    end else if (advance) begin
      phase_r   <= phase_nxt;
      last_ms_r <= last_ms_nxt;
    end
  end

endmodule

/* design/slad_color.sv */
// Shift ladder and alarm color selection for one telemetry word.
module slad_color (
  input  slad_pkg::item_t    item,
  input  slad_pkg::cfg_t     cfg,
  input  logic               phase,
  output slad_pkg::led_vec_t leds
);
  import slad_pkg::*;

  logic [16:0] shift;
  logic [16:0] rpm;
  logic [16:0] start;
  logic [16:0] step;
  logic [16:0] thr1;
  logic [16:0] thr2;
  logic [16:0] thr3;
  logic [ColorW-1:0] strobe_col;
  logic        water_hot;
  logic        bat_low;
  logic        exh_hot;
  logic        over_rev;

  assign shift = {1'b0, cfg.shift_point_rpm};
  assign rpm   = {1'b0, item.engine_rpm};

  always_comb begin
    if (shift > LadderSpanRpm) begin
      start = shift - LadderSpanRpm;
      step  = LadderSpanRpm >> 2;
    end else begin
      start = '0;
      step  = (shift >> 2 == 17'd0) ? 17'd1 : shift >> 2;
    end
  end

  assign thr1 = start + step;
  assign thr2 = start + (step << 1);
  assign thr3 = thr2 + step;
  assign strobe_col = phase ? ColBlue : ColOff;

  assign water_hot = (cfg.water_alarm_c != 8'd0) &&
                     ($signed({item.coolant_c[8], item.coolant_c}) >=
                      $signed({2'b00, cfg.water_alarm_c}));
  assign bat_low   = (item.battery_mv < cfg.low_battery_mv) && (item.battery_mv > BatteryMinMv);
  assign exh_hot   = (cfg.exhaust_alarm_c != 11'd0) &&
                     (item.egt_c >= cfg.exhaust_alarm_c);
  assign over_rev  = (cfg.rev_limit_rpm != 16'd0) && (item.engine_rpm >= cfg.rev_limit_rpm);

  always_comb begin
    leds = '0;
    if (!cfg.shift_enable) begin
      for (int i = 0; i < 5; i++) leds[i] = ColOff;
    end else if (rpm >= shift) begin
      for (int i = 0; i < 5; i++) leds[i] = strobe_col;
    end else begin
      leds[0] = (rpm >= start) ? ColGreen : ColOff;
      leds[1] = (rpm >= thr1) ? ColGreen : ColOff;
      leds[2] = (rpm >= thr2) ? ColAmber : ColOff;
      leds[3] = (rpm >= thr3) ? ColOrange : ColOff;
      leds[4] = (rpm + RedMarginRpm >= shift) ? ColRed : ColOff;
    end

    if (!cfg.alarm_enable) begin
      leds[5] = ColOff;
      leds[6] = ColOff;
    end else begin
      if (water_hot)    leds[5] = phase ? ColRed : ColOff;
      else if (bat_low) leds[5] = ColBattery;
      else              leds[5] = ColOff;

      if (exh_hot)       leds[6] = phase ? ColMagenta : ColOff;
      else if (over_rev) leds[6] = phase ? ColWhite : ColRed;
      else               leds[6] = ColOff;
    end
  end

endmodule

/* design/shift_light_and_alarm_led_driver.sv */
// Top level of the shift light and alarm LED driver: stream stages, strobe, colors, registers.
//
// Each input word carries a millisecond timestamp and engine telemetry and yields one output
// word of seven 0xRRGGBB colors, LED 0 in the lowest 24 bits. The block takes one word per
// clock cycle while out_tready does not stall it. An accepted word is held in the input
// register, then the strobe update and all color selection happen in the single step into
// the output register. The strobe advances in word order as each word enters the output
// register. Back-pressure from out_tready reaches in_tready in the same cycle.
// Registers sit at byte addresses 4*i and are meant to be written while no word is in flight.
module shift_light_and_alarm_led_driver (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // Fields from bit 0: now_ms[31:0], engine_rpm[47:32], coolant temperature[56:48],
  // battery_mv[71:57], exhaust temperature[82:72], zero fill [87:83].
  input  logic [slad_pkg::InDataW-1:0]   in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // Fields from bit 0: led0_color .. led6_color, 24 bits each.
  output logic [slad_pkg::OutDataW-1:0]  out_tdata,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [slad_pkg::CfgAddrW-1:0]  cfg_paddr,
  input  logic [slad_pkg::CfgDataW-1:0]  cfg_pwdata,
  output logic [slad_pkg::CfgDataW-1:0]  cfg_prdata,
  output logic                           cfg_pready
);
  import slad_pkg::*;

  cfg_t     cfg;
  item_t    item_in;
  item_t    s1_item_r;
  logic     s1_valid_r;
  logic     s1_valid_nxt;
  logic     out_valid_r;
  logic     out_valid_nxt;
  led_vec_t leds;
  led_vec_t out_leds_r;
  logic     phase;
  logic     in_acc;
  logic     out_free;
  logic     adv;

  slad_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  assign item_in.now_ms     = in_tdata[31:0];
  assign item_in.engine_rpm = in_tdata[47:32];
  assign item_in.coolant_c  = in_tdata[56:48];
  assign item_in.battery_mv = in_tdata[71:57];
  assign item_in.egt_c      = in_tdata[82:72];

  assign out_free  = !out_valid_r || out_tready;
  assign adv       = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || adv;
  assign in_acc    = in_tvalid && in_tready;

  assign s1_valid_nxt  = in_acc || (s1_valid_r && !adv);
  assign out_valid_nxt = adv || (out_valid_r && !out_tready);

  slad_strobe u_strobe (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (adv),
    .now_ms  (s1_item_r.now_ms),
    .phase   (phase)
  );

  slad_color u_color (
    .item  (s1_item_r),
    .cfg   (cfg),
    .phase (phase),
    .leds  (leds)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r <= item_in;
    end
    if (adv) begin
      out_leds_r <= leds;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_leds_r;

endmodule

/* dv/slad_led_checker.sv */
// Checker for the shift light and alarm LED driver: predicts each output word and compares it.
module slad_led_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  input  logic                          in_tready,
  // Fields from bit 0: now_ms, engine_rpm, coolant temperature, battery_mv,
  // exhaust temperature.
  input  logic [slad_pkg::InDataW-1:0]  in_tdata,
  input  logic                          out_tvalid,
  input  logic                          out_tready,
  // Fields from bit 0: led0_color .. led6_color.
  input  logic [slad_pkg::OutDataW-1:0] out_tdata,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic                          cfg_pready,
  input  logic [slad_pkg::CfgAddrW-1:0] cfg_paddr,
  input  logic [slad_pkg::CfgDataW-1:0] cfg_pwdata,
  output int                            failures,
  output int                            words_due
);
  import slad_pkg::*;

  localparam int unsigned LadderSteps = 4;

  cfg_t        regs_now;
  logic        strobe_on;
  logic [31:0] last_toggle_ms;
  led_vec_t    expected_leds[$];

  // Advances the strobe for one telemetry word, then picks all seven colors.
  function automatic led_vec_t predict_leds(item_t reading);
    led_vec_t    leds;
    logic [31:0] elapsed;
    logic [16:0] shift_pt;
    logic [16:0] rpm;
    logic [16:0] ladder_start;
    logic [16:0] ladder_step;
    int          water;
    elapsed = reading.now_ms - last_toggle_ms;
    if (elapsed >= StrobePeriodMs) begin
      strobe_on      = ~strobe_on;
      last_toggle_ms = reading.now_ms;
    end
    shift_pt = {1'b0, regs_now.shift_point_rpm};
    rpm      = {1'b0, reading.engine_rpm};
    water    = $signed(reading.coolant_c);
    leds     = '0;

    if (regs_now.shift_enable && rpm >= shift_pt) begin
      for (int n = 0; n < 5; n++)
        leds[n] = strobe_on ? ColBlue : ColOff;
    end else if (regs_now.shift_enable) begin
      ladder_start = (shift_pt > LadderSpanRpm) ? shift_pt - LadderSpanRpm : '0;
      ladder_step  = 17'((shift_pt - ladder_start) / LadderSteps);
      if (ladder_step == 0)
        ladder_step = 17'd1;
      leds[0] = (rpm >= ladder_start)                   ? ColGreen  : ColOff;
      leds[1] = (rpm >= ladder_start + ladder_step)     ? ColGreen  : ColOff;
      leds[2] = (rpm >= ladder_start + 2 * ladder_step) ? ColAmber  : ColOff;
      leds[3] = (rpm >= ladder_start + 3 * ladder_step) ? ColOrange : ColOff;
      leds[4] = (rpm + RedMarginRpm >= shift_pt)        ? ColRed    : ColOff;
    end

    if (regs_now.alarm_enable) begin
      if (regs_now.water_alarm_c != 0 && water >= int'(regs_now.water_alarm_c))
        leds[5] = strobe_on ? ColRed : ColOff;
      else if (reading.battery_mv < regs_now.low_battery_mv &&
               reading.battery_mv > BatteryMinMv)
        leds[5] = ColBattery;

      if (regs_now.exhaust_alarm_c != 0 && reading.egt_c >= regs_now.exhaust_alarm_c)
        leds[6] = strobe_on ? ColMagenta : ColOff;
      else if (regs_now.rev_limit_rpm != 0 && reading.engine_rpm >= regs_now.rev_limit_rpm)
        leds[6] = strobe_on ? ColWhite : ColRed;
    end
    return leds;
  endfunction

  always @(posedge clk) begin : watch
    led_vec_t got;
    led_vec_t want;
    if (!rst_n) begin
      regs_now.shift_enable    = 1'b1;
      regs_now.shift_point_rpm = 16'd7000;
      regs_now.alarm_enable    = 1'b1;
      regs_now.water_alarm_c   = 8'd105;
      regs_now.low_battery_mv  = 15'd3400;
      regs_now.exhaust_alarm_c = 11'd850;
      regs_now.rev_limit_rpm   = 16'd0;
      strobe_on                = 1'b0;
      last_toggle_ms           = '0;
      expected_leds.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[CfgAddrW-1:2])
          REG_SHIFT_ENABLE:    regs_now.shift_enable    = cfg_pwdata[0];
          REG_SHIFT_POINT_RPM: regs_now.shift_point_rpm = cfg_pwdata[15:0];
          REG_ALARM_ENABLE:    regs_now.alarm_enable    = cfg_pwdata[0];
          REG_WATER_ALARM_C:   regs_now.water_alarm_c   = cfg_pwdata[7:0];
          REG_LOW_BATTERY_MV:  regs_now.low_battery_mv  = cfg_pwdata[14:0];
          REG_EXHAUST_ALARM_C: regs_now.exhaust_alarm_c = cfg_pwdata[10:0];
          REG_REV_LIMIT_RPM:   regs_now.rev_limit_rpm   = cfg_pwdata[15:0];
          default: ;
        endcase
      end

      // Compare before predicting, so a word can never be matched to its own input.
      if (out_tvalid && out_tready) begin
        got = led_vec_t'(out_tdata);
        if (expected_leds.size() == 0) begin
          if (failures < 10)
            $display("unexpected output word %h", out_tdata);
          failures++;
        end else begin
          want = expected_leds.pop_front();
          for (int led = 0; led < NumLeds; led++) begin
            if (got[led] !== want[led]) begin
              if (failures < 10)
                $display("LED %0d color: expected %06h, got %06h", led, want[led], got[led]);
              failures++;
            end
          end
        end
      end

      if (in_tvalid && in_tready)
        expected_leds.push_back(predict_leds(item_t'(in_tdata[$bits(item_t)-1:0])));
    end
    words_due = expected_leds.size();
  end

endmodule

/* dv/tb.sv */
// Testbench top for the shift light and alarm LED driver: stimulus, register setup and verdict.
module tb;
  import slad_pkg::*;

  localparam int unsigned HalfPeriod    = 6;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned PhaseCount    = 10;
  localparam int unsigned WordsPerPhase = 83;
  // Byte address just past the last register; writes there must change nothing.
  localparam logic [CfgAddrW-1:0] UnusedRegAddr = 5'd28;

  logic                clk;
  logic                rst_n       = 1'b0;
  logic                in_tvalid   = 1'b0;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata    = '0;
  logic                out_tvalid;
  logic                out_tready  = 1'b1;
  logic [OutDataW-1:0] out_tdata;
  logic                cfg_psel    = 1'b0;
  logic                cfg_penable = 1'b0;
  logic                cfg_pwrite  = 1'b0;
  logic [CfgAddrW-1:0] cfg_paddr   = '0;
  logic [CfgDataW-1:0] cfg_pwdata  = '0;
  logic [CfgDataW-1:0] cfg_prdata;
  logic                cfg_pready;

  int          failures;
  int          words_due;
  int          quiet_cycles;
  int unsigned sender_idle_pct = 0;
  int unsigned recv_stall_pct  = 0;
  cfg_t        cur_cfg;
  logic [31:0] clock_ms;

  shift_light_and_alarm_led_driver i_dut (.*);

  slad_led_checker i_checker (.*);

  always begin
    clk = 1'b0;
    #HalfPeriod;
    clk = 1'b1;
    #HalfPeriod;
  end

  always @(negedge clk)
    out_tready <= ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_psel && cfg_penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("tb NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic int clamp(int v, int lo, int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Half of the writes carry junk above the register width, which must be dropped.
  function automatic logic [31:0] with_junk(logic [31:0] v, int unsigned w);
    return $urandom_range(1) ? (v | ($urandom() << w)) : v;
  endfunction

  task automatic send_word(item_t reading);
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(InDataW - $bits(item_t)){1'b0}}, reading};
    do
      @(posedge clk);
    while (!in_tready);
  endtask

  task automatic send_reading(logic [31:0] now, int rpm, int water, int bat, int exh);
    item_t reading;
    reading.now_ms     = now;
    reading.engine_rpm = rpm[15:0];
    reading.coolant_c  = water[8:0];
    reading.battery_mv = bat[14:0];
    reading.egt_c      = exh[10:0];
    send_word(reading);
  endtask

  task automatic bus_write(logic [CfgAddrW-1:0] addr, logic [CfgDataW-1:0] value);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // Every telemetry word yields a word, so an empty scoreboard means the block is idle.
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (words_due != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic apply_config(int phase);
    cfg_t c;
    case (phase)
      1: c = '{1'b1, 16'd0, 1'b1, 8'd250, 15'd20000, 11'd1500, 16'd1};
      2: c = '{1'b1, 16'd65535, 1'b1, 8'd0, 15'd0, 11'd0, 16'd65535};
      3: c = '{1'b1, 16'd30, 1'b1, 8'd1, 15'd1001, 11'd1, 16'd0};
      4: c = '{1'b0, 16'd5000, 1'b0, 8'd100, 15'd12000, 11'd700, 16'd6000};
      5: c = '{1'b1, 16'd1600, 1'b1, 8'd120, 15'd14000, 11'd900, 16'd1500};
      6: c = '{1'b1, 16'd1601, 1'b1, 8'd60, 15'd4000, 11'd400, 16'd1200};
      default: begin
        c.shift_enable    = ($urandom_range(3) != 0);
        c.shift_point_rpm = 16'($urandom_range(1) ? $urandom_range(12000, 1000)
                                                  : $urandom_range(65535));
        c.alarm_enable    = ($urandom_range(3) != 0);
        c.water_alarm_c   = 8'($urandom_range(250));
        c.low_battery_mv  = 15'($urandom_range(20000));
        c.exhaust_alarm_c = 11'($urandom_range(1500));
        c.rev_limit_rpm   = 16'($urandom_range(1) ? $urandom_range(12000, 1000) : 0);
      end
    endcase
    bus_write({REG_SHIFT_ENABLE, 2'b00},    with_junk(32'(c.shift_enable), 1));
    bus_write({REG_SHIFT_POINT_RPM, 2'b00}, with_junk(32'(c.shift_point_rpm), 16));
    bus_write({REG_ALARM_ENABLE, 2'b00},    with_junk(32'(c.alarm_enable), 1));
    bus_write({REG_WATER_ALARM_C, 2'b00},   with_junk(32'(c.water_alarm_c), 8));
    bus_write({REG_LOW_BATTERY_MV, 2'b00},  with_junk(32'(c.low_battery_mv), 15));
    bus_write({REG_EXHAUST_ALARM_C, 2'b00}, with_junk(32'(c.exhaust_alarm_c), 11));
    bus_write({REG_REV_LIMIT_RPM, 2'b00},   with_junk(32'(c.rev_limit_rpm), 16));
    if (phase == PhaseCount - 1)
      bus_write(UnusedRegAddr, $urandom());
    cur_cfg = c;
  endtask

  // Readings cluster around the current thresholds so that every ladder step and alarm flips.
  function automatic item_t make_reading();
    item_t       reading;
    int unsigned pick;
    int          rpm;
    int          water;
    int          bat;
    int          exh;
    pick = $urandom_range(19);
    if (pick == 0)
      clock_ms = $urandom();
    else if (pick == 1)
      clock_ms = clock_ms + StrobePeriodMs;
    else
      clock_ms = clock_ms + $urandom_range(130);

    pick = $urandom_range(9);
    if (pick < 5)
      rpm = clamp(int'(cur_cfg.shift_point_rpm) + int'($urandom_range(1800)) - 1700, 0, 65535);
    else if (pick < 7)
      rpm = clamp(int'(cur_cfg.rev_limit_rpm) + int'($urandom_range(200)) - 100, 0, 65535);
    else
      rpm = $urandom_range(65535);

    pick = $urandom_range(9);
    if (pick < 4)
      water = clamp(int'(cur_cfg.water_alarm_c) + int'($urandom_range(6)) - 3, -40, 250);
    else if (pick < 9)
      water = int'($urandom_range(290)) - 40;
    else
      water = $urandom_range(511);

    pick = $urandom_range(9);
    if (pick < 2)
      bat = clamp(int'(cur_cfg.low_battery_mv) + int'($urandom_range(6)) - 3, 0, 20000);
    else if (pick < 3)
      bat = int'(BatteryMinMv) + int'($urandom_range(6)) - 3;
    else if (pick < 9)
      bat = $urandom_range(20000);
    else
      bat = $urandom_range(32767);

    pick = $urandom_range(9);
    if (pick < 4)
      exh = clamp(int'(cur_cfg.exhaust_alarm_c) + int'($urandom_range(6)) - 3, 0, 1500);
    else if (pick < 9)
      exh = $urandom_range(1500);
    else
      exh = $urandom_range(2047);

    reading.now_ms     = clock_ms;
    reading.engine_rpm = rpm[15:0];
    reading.coolant_c  = water[8:0];
    reading.battery_mv = bat[14:0];
    reading.egt_c      = exh[10:0];
    return reading;
  endfunction

  initial begin : stimulus
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    cur_cfg = '{1'b1, 16'd7000, 1'b1, 8'd105, 15'd3400, 11'd850, 16'd0};

    // With the reset settings the ladder starts at 5400 rpm in steps of 400.
    send_reading(32'd0,   0,     -40,  0,     0);
    send_reading(32'd59,  5399,  104,  1000,  849);
    send_reading(32'd60,  5400,  105,  1001,  850);
    send_reading(32'd119, 5799,  250,  3399,  1500);
    send_reading(32'd120, 5800,  0,    3400,  0);
    send_reading(32'd180, 6199,  -1,   20000, 1499);
    send_reading(32'd240, 6200,  106,  2000,  851);
    send_reading(32'd241, 6600,  50,   1500,  100);
    send_reading(32'd300, 6949,  20,   3000,  2047);
    send_reading(32'd360, 6950,  255,  32767, 2047);
    send_reading(32'd420, 6999,  -256, 16384, 1024);
    send_reading(32'd480, 7000,  100,  3300,  800);
    send_reading(32'd540, 7001,  100,  3300,  800);
    send_reading(32'd600, 65535, 105,  1200,  850);
    send_reading(32'd601, 65535, 104,  1200,  849);
    // Elapsed time is taken modulo 2^32 across the wrap of the millisecond counter.
    send_reading(32'hFFFF_FFC0, 7000, 110, 2500, 900);
    send_reading(32'h0000_0010, 7000, 110, 2500, 900);
    send_reading(32'h0000_0030, 7000, 110, 2500, 900);
    send_reading(32'h0000_004C, 7000, 110, 2500, 900);
    send_reading(32'h7FFF_FFFF, 6000, 30,  12000, 300);
    send_reading(32'h8000_0000, 0,    30,  12000, 300);
    clock_ms = 32'h8000_0000;

    for (int phase = 0; phase < PhaseCount; phase++) begin
      if (phase != 0) begin
        drain();
        apply_config(phase);
      end
      case (phase % 4)
        0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin sender_idle_pct = 67; recv_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  recv_stall_pct = 67; end
        default: begin sender_idle_pct = 36; recv_stall_pct = 36; end
      endcase
      for (int n = 0; n < WordsPerPhase; n++)
        send_word(make_reading());
    end

    drain();
    repeat (8) @(negedge clk);
    if (failures == 0 && words_due == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

endmodule

/* sim.f */
design/slad_pkg.sv
design/slad_cfg.sv
design/slad_strobe.sv
design/slad_color.sv
design/shift_light_and_alarm_led_driver.sv
dv/slad_led_checker.sv
dv/tb.sv
